// ----- sv/mhid_pkg.sv -----
// ----------------------------------------------------------------------------
// mhid_pkg
// Shared types and constants of the max heap block: field widths, status
// codes, datapath operations, controller states and the status bundle.
// ----------------------------------------------------------------------------
package mhid_pkg;

  // default heap depth
  localparam int MHID_CAPACITY = 16;

  // field widths
  localparam int KEY_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int TOTAL_W    = 5;
  localparam int OUT_DATA_W = 40;

  // request kinds
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_code_t;

  // one datapath operation per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_APPEND,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_LAST_RD,
    OP_DEL_WR_POS,
    OP_DEL_WR_LAST,
    OP_OUTER,
    OP_RD_CUR,
    OP_RD_LC,
    OP_RD_RC,
    OP_TAKE_RC,
    OP_WR_CUR,
    OP_WR_BEST,
    OP_RD_TOP,
    OP_RESULT
  } dp_op_t;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_APPEND,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_LAST_RD,
    S_DEL_WR_POS,
    S_DEL_WR_LAST,
    S_OUTER,
    S_RD_CUR,
    S_RD_LC,
    S_RD_RC,
    S_TAKE_RC,
    S_WR_CUR,
    S_WR_BEST,
    S_RD_TOP,
    S_RESULT
  } state_t;

  // datapath flags seen by the controller
  typedef struct packed {
    logic cmd_delete;
    logic bad;
    logic scan_match;
    logic scan_last;
    logic k_zero;
    logic best_is_cur;
    logic out_free;
  } dp_status_t;

endpackage

// ----- sv/mhid_ctrl.sv -----
// ----------------------------------------------------------------------------
// mhid_ctrl
// Sequencer of the heap: walks a request through decode, key search,
// append or swap-out, and the rebuild loop of sift-downs, issuing one
// datapath operation each cycle.
// ----------------------------------------------------------------------------
module mhid_ctrl import mhid_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_op_t     op
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (st.bad)             state_next = S_RD_TOP;
        else if (st.cmd_delete) state_next = S_SCAN_RD;
        else                    state_next = S_APPEND;
      end
      S_APPEND:      state_next = S_OUTER;
      S_SCAN_RD:     state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (st.scan_match)     state_next = S_LAST_RD;
        else if (st.scan_last) state_next = S_RD_TOP;
        else                   state_next = S_SCAN_RD;
      end
      S_LAST_RD:     state_next = S_DEL_WR_POS;
      S_DEL_WR_POS:  state_next = S_DEL_WR_LAST;
      S_DEL_WR_LAST: state_next = S_OUTER;
      S_OUTER: begin
        state_next = st.k_zero ? S_RD_TOP : S_RD_CUR;
      end
      S_RD_CUR:      state_next = S_RD_LC;
      S_RD_LC:       state_next = S_RD_RC;
      S_RD_RC:       state_next = S_TAKE_RC;
      S_TAKE_RC:     state_next = S_WR_CUR;
      S_WR_CUR: begin
        state_next = st.best_is_cur ? S_OUTER : S_WR_BEST;
      end
      S_WR_BEST:     state_next = S_RD_CUR;
      S_RD_TOP:      state_next = S_RESULT;
      S_RESULT: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default:       state_next = S_IDLE;
    endcase
  end

  // operation decode
  always_comb begin
    in_ready = 1'b0;
    op       = OP_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_ACCEPT;
      end
      S_DECODE:      op = OP_NONE;
      S_APPEND:      op = OP_APPEND;
      S_SCAN_RD:     op = OP_SCAN_RD;
      S_SCAN_CMP:    op = OP_SCAN_CMP;
      S_LAST_RD:     op = OP_LAST_RD;
      S_DEL_WR_POS:  op = OP_DEL_WR_POS;
      S_DEL_WR_LAST: op = OP_DEL_WR_LAST;
      S_OUTER:       op = st.k_zero ? OP_NONE : OP_OUTER;
      S_RD_CUR:      op = OP_RD_CUR;
      S_RD_LC:       op = OP_RD_LC;
      S_RD_RC:       op = OP_RD_RC;
      S_TAKE_RC:     op = OP_TAKE_RC;
      S_WR_CUR:      op = st.best_is_cur ? OP_NONE : OP_WR_CUR;
      S_WR_BEST:     op = OP_WR_BEST;
      S_RD_TOP:      op = OP_RD_TOP;
      S_RESULT:      op = st.out_free ? OP_RESULT : OP_NONE;
      default:       op = OP_NONE;
    endcase
  end

endmodule

// ----- sv/mhid_dp.sv -----
// ----------------------------------------------------------------------------
// mhid_dp
// Heap datapath: key memory with registered read, entry count, search
// pointer, rebuild counter, sift-down node and child registers, and the
// result register toward the output channel.
// ----------------------------------------------------------------------------
module mhid_dp import mhid_pkg::*; #(
  parameter int CAPACITY = MHID_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_op_t              op,
  input  logic                cmd_in,
  input  logic [KEY_W-1:0]    key_in,
  output dp_status_t          st,
  input  logic                res_ready,
  output logic                res_valid,
  output logic [STATUS_W-1:0] res_status,
  output logic [KEY_W-1:0]    res_top,
  output logic [TOTAL_W-1:0]  res_total
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  // key memory
  logic [KEY_W-1:0] mem [CAPACITY];
  logic [KEY_W-1:0] rd_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;

  // control registers
  logic [CW-1:0]    count;
  logic             out_valid;

  // working registers
  logic [KEY_W-1:0] key;
  logic             cmd;
  status_code_t     status;
  logic [AW-1:0]    pos;
  logic [CW-1:0]    k;
  logic [AW-1:0]    cur;
  logic [AW-1:0]    best;
  logic [KEY_W-1:0] cur_val;
  logic [KEY_W-1:0] best_val;

  // child indices and bounds
  logic [IW-1:0]    lc_w;
  logic [IW-1:0]    rc_w;
  logic [IW-1:0]    count_w;
  logic             lc_ok;
  logic             rc_ok;
  logic [AW-1:0]    last_idx;
  logic [CW-1:0]    count_inc;
  logic             rd_gt_best;

  assign lc_w       = {1'b0, cur, 1'b1};
  assign rc_w       = {1'b0, cur, 1'b0} + IW'(2);
  assign count_w    = IW'(count);
  assign lc_ok      = lc_w < count_w;
  assign rc_ok      = rc_w < count_w;
  assign last_idx   = AW'(count - CW'(1));
  assign count_inc  = count + CW'(1);
  assign rd_gt_best = $signed(rd_data) > $signed(best_val);

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = key;
    case (op)
      OP_SCAN_RD: begin
        rd_en   = 1'b1;
        rd_addr = pos;
      end
      OP_LAST_RD: begin
        rd_en   = 1'b1;
        rd_addr = last_idx;
      end
      OP_RD_CUR: begin
        rd_en   = 1'b1;
        rd_addr = cur;
      end
      OP_RD_LC: begin
        rd_en   = lc_ok;
        rd_addr = lc_w[AW-1:0];
      end
      OP_RD_RC: begin
        rd_en   = rc_ok;
        rd_addr = rc_w[AW-1:0];
      end
      OP_RD_TOP: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      OP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = AW'(count);
        wr_data = key;
      end
      OP_DEL_WR_POS: begin
        wr_en   = 1'b1;
        wr_addr = pos;
        wr_data = rd_data;
      end
      OP_DEL_WR_LAST: begin
        wr_en   = 1'b1;
        wr_addr = last_idx;
        wr_data = key;
      end
      OP_WR_CUR: begin
        wr_en   = 1'b1;
        wr_addr = cur;
        wr_data = best_val;
      end
      OP_WR_BEST: begin
        wr_en   = 1'b1;
        wr_addr = best;
        wr_data = cur_val;
      end
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  // memory array, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // entry count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (op == OP_APPEND) begin
        count <= count_inc;
      end else if (op == OP_DEL_WR_LAST) begin
        count <= count - CW'(1);
      end
      if (op == OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (res_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        key <= key_in;
        cmd <= cmd_in;
        pos <= '0;
        if (cmd_in == CMD_INSERT && count == CW'(CAPACITY)) begin
          status <= ST_FULL;
        end else if (cmd_in == CMD_DELETE && count == '0) begin
          status <= ST_NOT_FOUND;
        end else begin
          status <= ST_DONE;
        end
      end
      OP_APPEND: begin
        k <= count_inc >> 1;
      end
      OP_SCAN_CMP: begin
        if (rd_data != key) begin
          pos <= pos + AW'(1);
          if (st.scan_last) status <= ST_NOT_FOUND;
        end
      end
      OP_DEL_WR_LAST: begin
        k <= count - CW'(1);
      end
      OP_OUTER: begin
        k   <= k - CW'(1);
        cur <= AW'(k - CW'(1));
      end
      OP_RD_LC: begin
        cur_val  <= rd_data;
        best_val <= rd_data;
        best     <= cur;
      end
      OP_RD_RC: begin
        if (lc_ok && rd_gt_best) begin
          best     <= lc_w[AW-1:0];
          best_val <= rd_data;
        end
      end
      OP_TAKE_RC: begin
        if (rc_ok && rd_gt_best) begin
          best     <= rc_w[AW-1:0];
          best_val <= rd_data;
        end
      end
      OP_WR_BEST: begin
        cur <= best;
      end
      OP_RESULT: begin
        res_status <= status;
        res_top    <= (count != '0) ? rd_data : '0;
        res_total  <= TOTAL_W'(count);
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  // status toward the controller
  assign st.cmd_delete  = (cmd == CMD_DELETE);
  assign st.bad         = (status != ST_DONE);
  assign st.scan_match  = (rd_data == key);
  assign st.scan_last   = (CW'(pos) + CW'(1) == count);
  assign st.k_zero      = (k == '0);
  assign st.best_is_cur = (best == cur);
  assign st.out_free    = !out_valid || res_ready;

  assign res_valid = out_valid;

  // count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // an append only happens with a free slot
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    (op == OP_APPEND) |-> (count < CW'(CAPACITY)))
    else $error("append into a full heap");

  // count moves only on append or removal
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !(op == OP_APPEND || op == OP_DEL_WR_LAST) |=> $stable(count))
    else $error("entry count changed without append or removal");

  // loading a result raises valid
  a_result_valid: assert property (@(posedge clk) disable iff (rst)
    (op == OP_RESULT) |=> out_valid)
    else $error("result loaded but not presented");

endmodule

// ----- sv/max_heap_insert_delete.sv -----
// ----------------------------------------------------------------------------
// max_heap_insert_delete
// Binary max heap of signed 32-bit keys with insert and delete-by-key.
//
// Input channel s_*: one request per transfer, s_tuser is the kind
// (insert or delete) and s_tdata the key. Output channel m_*: one result
// per request with status, largest stored key and entry count.
// Requests are taken one at a time; s_tready is high only while the
// sequencer is idle. Every heap access goes through the single read and
// single write port of the key memory, so each step is a state of its own:
//   overhead: accept, decode, read top, load result; append: one write
//   delete: read and compare per entry, read last, write found and last slot
//   rebuild: a step per outer-loop node and a final exit check, then per
//   sift-down level reads of node and both children, compares, a node
//   write, and a write of the child for each swap
// An insert rebuilds nodes n/2-1 down to 0, a delete every node n-1 down
// to 0. Reset empties the heap at once; no clearing pass is needed.
// A result waits in the output register while m_tready is low; the next
// request may be taken meanwhile, and its result waits for the slot.
// ----------------------------------------------------------------------------
module max_heap_insert_delete import mhid_pkg::*; #(
  parameter int CAPACITY = MHID_CAPACITY
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [KEY_W-1:0]      s_tdata,   // key
  input  logic [0:0]            s_tuser,   // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // status, top_value, entry_total, zero pad
);

  dp_op_t                op;
  dp_status_t            st;
  logic [STATUS_W-1:0]   res_status;
  logic [KEY_W-1:0]      res_top;
  logic [TOTAL_W-1:0]    res_total;

  // sequencer
  mhid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .op       (op)
  );

  // heap datapath
  mhid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .cmd_in     (s_tuser[0]),
    .key_in     (s_tdata),
    .st         (st),
    .res_ready  (m_tready),
    .res_valid  (m_tvalid),
    .res_status (res_status),
    .res_top    (res_top),
    .res_total  (res_total)
  );

  // result packing, lowest field first
  assign m_tdata = {1'b0, res_total, res_top, res_status};

endmodule
